// ===== rtl/core/tcw_pkg.sv =====
package tcw_pkg;

  // Screen geometry.
  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;
  localparam int unsigned ADDR_W  = $clog2(CELLS);

  // Field widths.
  localparam int unsigned CELL_W  = 16;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned NUM_W   = 32;
  localparam int unsigned IDX_W   = 11;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUTC  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEC   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_HEX   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  // Character constants.
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT   = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_LETTER  = 8'd87;
  localparam logic [7:0]        ATTR_RESET   = 8'd15;

  // Highest digit position for each base.
  localparam logic [3:0] DEC_TOP = 4'd9;
  localparam logic [3:0] HEX_TOP = 4'd7;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MINUS,
    OP_DIGIT,
    OP_GLYPH,
    OP_SCR_RD,
    OP_SCR_WR,
    OP_ZERO,
    OP_RD,
    OP_CAPTURE,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic minus_pending;
    logic num_done;
    logic digit_emit;
    logic need_scroll;
    logic copy_last;
    logic zero_last;
    logic clearing;
    logic out_blocked;
  } dp_status_t;

  // Powers of ten for the decimal digit positions.
  function automatic logic [NUM_W-1:0] pow10(input logic [3:0] k);
    logic [NUM_W-1:0] p;
    unique case (k)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      4'd9:    p = 32'd1000000000;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/tcw_ram.sv =====
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/tcw_ctrl.sv =====
module tcw_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [tcw_pkg::CMD_W-1:0] command_i,
  input  tcw_pkg::dp_status_t      status_i,
  output tcw_pkg::dp_cmd_t         cmd_o
);

  import tcw_pkg::*;

  typedef enum logic [10:0] {
    S_INIT    = 11'b000_0000_0001,
    S_IDLE    = 11'b000_0000_0010,
    S_DISP    = 11'b000_0000_0100,
    S_DIGIT   = 11'b000_0000_1000,
    S_GLYPH   = 11'b000_0001_0000,
    S_SCR_RD  = 11'b000_0010_0000,
    S_SCR_WR  = 11'b000_0100_0000,
    S_ZERO    = 11'b000_1000_0000,
    S_RD      = 11'b001_0000_0000,
    S_RD_WAIT = 11'b010_0000_0000,
    S_RESULT  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and datapath operation.
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_INIT: begin
        cmd_o.op = OP_ZERO;
        if (status_i.zero_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          unique case (command_i)
            CMD_PUTC:  state_d = S_GLYPH;
            CMD_DEC:   state_d = S_DISP;
            CMD_HEX:   state_d = S_DISP;
            CMD_CLEAR: state_d = S_ZERO;
            CMD_READ:  state_d = S_RD;
            default:   state_d = S_RESULT;
          endcase
        end
      end
      S_DISP: begin
        if (status_i.minus_pending) begin
          cmd_o.op = OP_MINUS;
          state_d  = S_GLYPH;
        end else if (!status_i.num_done) begin
          state_d = S_DIGIT;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_DIGIT: begin
        cmd_o.op = OP_DIGIT;
        if (status_i.digit_emit) state_d = S_GLYPH;
      end
      S_GLYPH: begin
        cmd_o.op = OP_GLYPH;
        state_d  = status_i.need_scroll ? S_SCR_RD : S_DISP;
      end
      S_SCR_RD: begin
        cmd_o.op = OP_SCR_RD;
        state_d  = S_SCR_WR;
      end
      S_SCR_WR: begin
        cmd_o.op = OP_SCR_WR;
        state_d  = status_i.copy_last ? S_ZERO : S_SCR_RD;
      end
      S_ZERO: begin
        cmd_o.op = OP_ZERO;
        if (status_i.zero_last) state_d = status_i.clearing ? S_RESULT : S_DISP;
      end
      S_RD: begin
        cmd_o.op = OP_RD;
        state_d  = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        cmd_o.op = OP_CAPTURE;
        state_d  = S_RESULT;
      end
      S_RESULT: begin
        if (!status_i.out_blocked) begin
          cmd_o.op = OP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/tcw_datapath.sv =====
module tcw_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tcw_pkg::dp_cmd_t           cmd_i,
  output tcw_pkg::dp_status_t        status_o,
  input  logic [tcw_pkg::CMD_W-1:0]  command_i,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code_i,
  input  logic signed [tcw_pkg::NUM_W-1:0] number_value_i,
  input  logic [tcw_pkg::IDX_W-1:0]  cell_index_i,
  input  logic                       text_attribute_we_i,
  input  logic [7:0]                 text_attribute_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tcw_pkg::CELL_W-1:0] cell_data_o,
  output logic [tcw_pkg::COL_W-1:0]  cursor_column_o,
  output logic [tcw_pkg::ROW_W-1:0]  cursor_line_o,
  output logic                       did_scroll_o
);

  import tcw_pkg::*;

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [7:0]        attr_q;
  logic [CMD_W-1:0]  cmd_q;
  logic [CHAR_W-1:0] glyph_q, glyph_d;
  logic              newline_q;
  logic [NUM_W-1:0]  mag_q, mag_d;
  logic              minus_q, minus_d;
  logic              hex_q;
  logic [3:0]        k_q, k_d;
  logic [3:0]        cnt_q, cnt_d;
  logic              started_q, started_d;
  logic              done_q, done_d;
  logic [ADDR_W-1:0] sweep_q, sweep_d;
  logic [IDX_W-1:0]  idx_q;
  logic              scroll_q, scroll_d;
  logic [CELL_W-1:0] data_q, data_d;
  logic              out_valid_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr, cur_addr, idx_addr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;
  logic              idx_ok;

  logic [NUM_W-1:0]  pow;
  logic              ge;
  logic [3:0]        digit;
  logic              emit;
  logic [CHAR_W-1:0] digit_char;
  logic              wrap;

  // Cursor cell address and read index check.
  assign cur_addr = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(COLUMNS)) + ADDR_W'(col_q);
  assign idx_ok   = (idx_q < IDX_W'(CELLS));
  assign idx_addr = idx_ok ? idx_q[ADDR_W-1:0] : '0;

  // Digit extraction: one hex position per step, or one subtract or emit step of a decimal position.
  assign pow   = pow10(k_q);
  assign ge    = (mag_q >= pow);
  assign digit = hex_q ? mag_q[{k_q[2:0], 2'b00} +: 4] : cnt_q;
  assign emit  = (digit != 4'd0) || started_q || (k_q == 4'd0);
  assign digit_char = (digit > 4'd9) ? (CHAR_LETTER + CHAR_W'(digit))
                                     : (CHAR_DIGIT + CHAR_W'(digit));
  assign wrap  = newline_q || (col_q == COL_W'(COLUMNS - 1));

  // Status to the controller.
  always_comb begin
    status_o.minus_pending = minus_q;
    status_o.num_done      = done_q;
    status_o.digit_emit    = (hex_q || !ge) && emit;
    status_o.need_scroll   = wrap && (row_q == ROW_W'(ROWS - 1));
    status_o.copy_last     = (sweep_q == ADDR_W'(CELLS - COLUMNS - 1));
    status_o.zero_last     = (sweep_q == ADDR_W'(CELLS - 1));
    status_o.clearing      = (cmd_q == CMD_CLEAR);
    status_o.out_blocked   = out_valid_q && out_stall_i;
  end

  // Character store.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_q;
    ram_wdata = '0;
    ram_raddr = idx_addr;
    unique case (cmd_i.op)
      OP_GLYPH: begin
        ram_we    = 1'b1;
        ram_waddr = cur_addr;
        ram_wdata = newline_q ? '0 : {attr_q, glyph_q};
      end
      OP_SCR_RD: ram_raddr = sweep_q + ADDR_W'(COLUMNS);
      OP_SCR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      OP_ZERO: ram_we = 1'b1;
      default: ;
    endcase
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next values of the working registers.
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    glyph_d   = glyph_q;
    mag_d     = mag_q;
    minus_d   = minus_q;
    k_d       = k_q;
    cnt_d     = cnt_q;
    started_d = started_q;
    done_d    = done_q;
    sweep_d   = sweep_q;
    scroll_d  = scroll_q;
    data_d    = data_q;
    unique case (cmd_i.op)
      OP_LOAD: begin
        scroll_d  = 1'b0;
        data_d    = '0;
        glyph_d   = char_code_i;
        mag_d     = number_value_i[NUM_W-1] ? (NUM_W'(0) - NUM_W'(number_value_i))
                                            : NUM_W'(number_value_i);
        minus_d   = 1'b0;
        done_d    = 1'b1;
        cnt_d     = '0;
        started_d = 1'b0;
        k_d       = (command_i == CMD_HEX) ? HEX_TOP : DEC_TOP;
        sweep_d   = '0;
        if ((command_i == CMD_DEC) || (command_i == CMD_HEX)) begin
          minus_d = number_value_i[NUM_W-1];
          done_d  = 1'b0;
        end
        if (command_i == CMD_CLEAR) begin
          col_d = '0;
          row_d = '0;
        end
      end
      OP_MINUS: begin
        glyph_d = CHAR_MINUS;
        minus_d = 1'b0;
      end
      OP_DIGIT: begin
        if (!hex_q && ge) begin
          mag_d = mag_q - pow;
          cnt_d = cnt_q + 4'd1;
        end else begin
          if (emit) begin
            glyph_d   = digit_char;
            started_d = 1'b1;
          end
          if (k_q == 4'd0) done_d = 1'b1;
          else             k_d    = k_q - 4'd1;
          cnt_d = '0;
        end
      end
      OP_GLYPH: begin
        if (wrap) begin
          col_d = '0;
          if (row_q == ROW_W'(ROWS - 1)) begin
            scroll_d = 1'b1;
            sweep_d  = '0;
          end else begin
            row_d = row_q + ROW_W'(1);
          end
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
      OP_SCR_WR: sweep_d = sweep_q + ADDR_W'(1);
      OP_ZERO:   sweep_d = sweep_q + ADDR_W'(1);
      OP_CAPTURE: data_d = idx_ok ? ram_rdata : '0;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      attr_q      <= ATTR_RESET;
      sweep_q     <= '0;
      minus_q     <= 1'b0;
      done_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      sweep_q <= sweep_d;
      minus_q <= minus_d;
      done_q  <= done_d;
      if (text_attribute_we_i) attr_q <= text_attribute_i;
      if (cmd_i.op == OP_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    glyph_q   <= glyph_d;
    mag_q     <= mag_d;
    k_q       <= k_d;
    cnt_q     <= cnt_d;
    started_q <= started_d;
    scroll_q  <= scroll_d;
    data_q    <= data_d;
    if (cmd_i.op == OP_LOAD) begin
      cmd_q     <= command_i;
      idx_q     <= cell_index_i;
      hex_q     <= (command_i == CMD_HEX);
      newline_q <= (command_i == CMD_PUTC) && (char_code_i == CHAR_NEWLINE);
    end else if (cmd_i.op == OP_MINUS) begin
      newline_q <= 1'b0;
    end
    if (cmd_i.op == OP_RESULT) begin
      cell_data_o     <= data_q;
      cursor_column_o <= col_q;
      cursor_line_o   <= row_q;
      did_scroll_o    <= scroll_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/text_console_writer.sv =====
// Text console writer: a character-cell screen of COLUMNS x ROWS 16-bit cells
// (attribute high byte, code low byte) with a cursor. After reset the block
// clears the screen in one pass over all COLUMNS*ROWS cells before it takes
// its first item. A plain character or newline writes its cell, then gives its
// result. A number runs one digit-unit step at a time (up to nine subtract
// steps and one emit step per decimal position, one step per hex position,
// leading zero positions included) and writes each printed character.
// Each scroll walks the store, reading then writing each moved cell, and
// clears each cell of the bottom row; a clear zeroes every cell; a read
// captures the registered store data. One item is worked on at a time, and
// the next is taken while the previous result waits in the output register.
module text_console_writer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [tcw_pkg::CMD_W-1:0]  command_i,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code_i,
  input  logic signed [tcw_pkg::NUM_W-1:0] number_value_i,
  input  logic [tcw_pkg::IDX_W-1:0]  cell_index_i,
  input  logic                       text_attribute_we_i,
  input  logic [7:0]                 text_attribute_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tcw_pkg::CELL_W-1:0] cell_data_o,
  output logic [tcw_pkg::COL_W-1:0]  cursor_column_o,
  output logic [tcw_pkg::ROW_W-1:0]  cursor_line_o,
  output logic                       did_scroll_o
);

  import tcw_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencing of each item.
  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Cursor, digit unit, store and result register.
  tcw_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .command_i           (command_i),
    .char_code_i         (char_code_i),
    .number_value_i      (number_value_i),
    .cell_index_i        (cell_index_i),
    .text_attribute_we_i (text_attribute_we_i),
    .text_attribute_i    (text_attribute_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .cell_data_o         (cell_data_o),
    .cursor_column_o     (cursor_column_o),
    .cursor_line_o       (cursor_line_o),
    .did_scroll_o        (did_scroll_o)
  );

endmodule

// ===== rtl/core/tcw_checker.sv =====
module tcw_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [tcw_pkg::CELL_W-1:0] cell_data_o,
  input logic [tcw_pkg::COL_W-1:0]  cursor_column_o,
  input logic [tcw_pkg::ROW_W-1:0]  cursor_line_o
);

  import tcw_pkg::*;

  // The cursor shown in a result always lies on the screen.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cursor_column_o < COL_W'(COLUMNS)))
    else $error("cursor column off screen");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cursor_line_o < ROW_W'(ROWS)))
    else $error("cursor line off screen");

  // An accepted item keeps the input side busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after an item");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(cell_data_o)))
    else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

// ===== tb/tb_text_console_writer.sv =====
module tb_text_console_writer;
  import tcw_pkg::*;

  // Command codes that the block leaves unused.
  localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
  localparam logic [CMD_W-1:0] CMD_NO_OP  = 3'd7;

  localparam int unsigned RAND_PER_PHASE = 150;
  localparam int unsigned LONG_HOLD      = 400;
  localparam longint      CYCLE_LIMIT    = 20000000;

  typedef struct {
    logic [CELL_W-1:0] data;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              scrolled;
  } cursor_report_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] code;
    logic [NUM_W-1:0]  num;
    logic [IDX_W-1:0]  idx;
    bit                typed;
    cursor_report_t    report;
  } stim_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         command = '0;
  logic [CHAR_W-1:0]        char_code = '0;
  logic signed [NUM_W-1:0]  number_value = '0;
  logic [IDX_W-1:0]         cell_index = '0;
  logic                     attr_we = 1'b0;
  logic [7:0]               attr_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [CELL_W-1:0]        cell_data;
  logic [COL_W-1:0]         cursor_column;
  logic [ROW_W-1:0]         cursor_line;
  logic                     did_scroll;

  text_console_writer dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .command_i           (command),
    .char_code_i         (char_code),
    .number_value_i      (number_value),
    .cell_index_i        (cell_index),
    .text_attribute_we_i (attr_we),
    .text_attribute_i    (attr_data),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .cell_data_o         (cell_data),
    .cursor_column_o     (cursor_column),
    .cursor_line_o       (cursor_line),
    .did_scroll_o        (did_scroll)
  );

  always #10 clk_i = ~clk_i;

  // Screen model: cells, cursor and attribute register.
  logic [CELL_W-1:0] screen_model [CELLS];
  int unsigned       model_col;
  int unsigned       model_row;
  logic [7:0]        model_attr;
  bit                model_scrolled;

  cursor_report_t pending_reports [$];
  stim_row_t      directed_rows [$];
  int unsigned    error_count = 0;
  bit             quiet_mode = 1'b0;
  bit             hold_request = 1'b0;
  longint         cycle_count = 0;

  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = '0;
    model_scrolled = 1'b1;
  endfunction

  function automatic void clamp_row();
    if (model_row > ROWS - 1) begin
      model_row = ROWS - 1;
      scroll_screen();
    end
  endfunction

  function automatic void write_glyph(logic [7:0] code);
    int unsigned pos;
    pos = model_row * COLUMNS + model_col;
    if (pos < CELLS) screen_model[pos] = {model_attr, code};
    model_col++;
    if (model_col >= COLUMNS) begin
      model_col = 0;
      model_row++;
    end
    clamp_row();
  endfunction

  function automatic void break_line();
    int unsigned pos;
    pos = model_row * COLUMNS + model_col;
    if (pos < CELLS) screen_model[pos] = '0;
    model_col = 0;
    model_row++;
    clamp_row();
  endfunction

  function automatic void print_number(logic [31:0] raw, int unsigned base);
    logic [31:0] mag;
    int unsigned digits [$];
    int unsigned d;
    mag = raw;
    if (raw[31]) begin
      write_glyph(CHAR_MINUS);
      mag = 32'd0 - raw;
    end
    do begin
      digits.push_front(mag % base);
      mag = mag / base;
    end while (mag != 0);
    foreach (digits[i]) begin
      d = digits[i];
      write_glyph(d > 9 ? 8'(d) + CHAR_LETTER : 8'(d) + CHAR_DIGIT);
    end
  endfunction

  // Applies one item to the screen model and returns the report it yields.
  function automatic cursor_report_t console_apply(logic [CMD_W-1:0] cmd, logic [7:0] code,
                                                   logic [31:0] num, logic [IDX_W-1:0] idx);
    cursor_report_t rep;
    rep.data = '0;
    model_scrolled = 1'b0;
    case (cmd)
      CMD_PUTC: begin
        if (code == CHAR_NEWLINE) break_line();
        else write_glyph(code);
      end
      CMD_DEC: print_number(num, 10);
      CMD_HEX: print_number(num, 16);
      CMD_CLEAR: begin
        foreach (screen_model[i]) screen_model[i] = '0;
        model_col = 0;
        model_row = 0;
      end
      CMD_READ: begin
        if (idx < CELLS) rep.data = screen_model[idx];
      end
      default: ;
    endcase
    rep.col = COL_W'(model_col);
    rep.row = ROW_W'(model_row);
    rep.scrolled = model_scrolled;
    return rep;
  endfunction

  // Hands one item to the block and records the report it must produce.
  task automatic send_item(stim_row_t r);
    cursor_report_t rep;
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid     <= 1'b1;
    command      <= r.cmd;
    char_code    <= r.code;
    number_value <= r.num;
    cell_index   <= r.idx;
    do @(posedge clk_i); while (in_stall);
    rep = console_apply(r.cmd, r.code, r.num, r.idx);
    pending_reports.push_back(r.typed ? r.report : rep);
    @(negedge clk_i);
  endtask

  task automatic go_idle_and_drain();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_attribute(logic [7:0] value);
    attr_we   <= 1'b1;
    attr_data <= value;
    @(negedge clk_i);
    attr_we   <= 1'b0;
    model_attr = value;
  endtask

  function automatic stim_row_t random_row();
    stim_row_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.typed = 1'b0;
    r.report = '{default: '0};
    r.code = CHAR_W'($urandom_range(0, 255));
    r.num = ($urandom_range(0, 1) == 1) ? $urandom : 32'($urandom_range(0, 200)) - 32'd100;
    r.idx = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 2047))
                                        : IDX_W'(model_row * COLUMNS + $urandom_range(0, 159));
    if (pick < 52) r.cmd = CMD_PUTC;
    else if (pick < 56) begin
      r.cmd = CMD_PUTC;
      r.code = CHAR_NEWLINE;
    end
    else if (pick < 66) r.cmd = CMD_DEC;
    else if (pick < 76) r.cmd = CMD_HEX;
    else if (pick < 94) r.cmd = CMD_READ;
    else if (pick < 96) r.cmd = CMD_CLEAR;
    else if (pick < 97) r.cmd = CMD_SPARE5;
    else if (pick < 98) r.cmd = CMD_SPARE6;
    else r.cmd = CMD_SPARE7;
    return r;
  endfunction

  function automatic void add_row(logic [CMD_W-1:0] cmd, logic [7:0] code, logic [31:0] num,
                                  logic [IDX_W-1:0] idx, bit typed, logic [CELL_W-1:0] data,
                                  logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    stim_row_t r;
    r.cmd = cmd;
    r.code = code;
    r.num = num;
    r.idx = idx;
    r.typed = typed;
    r.report = '{data, col, row, 1'b0};
    directed_rows.push_back(r);
  endfunction

  // Main sequence: reset, directed table, then random phases at several attributes.
  initial begin
    foreach (screen_model[i]) screen_model[i] = '0;
    model_col = 0;
    model_row = 0;
    model_attr = ATTR_RESET;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Fresh screen, out-of-range read, extremes of characters and numbers.
    add_row(CMD_READ, 8'd0, 32'd0, 11'd0, 1, 16'd0, 7'd0, 5'd0);
    add_row(CMD_READ, 8'd0, 32'd0, 11'd1999, 1, 16'd0, 7'd0, 5'd0);
    add_row(CMD_READ, 8'd0, 32'd0, 11'd2047, 1, 16'd0, 7'd0, 5'd0);
    add_row(CMD_PUTC, 8'd65, 32'd0, 11'd0, 1, 16'd0, 7'd1, 5'd0);
    add_row(CMD_READ, 8'd0, 32'd0, 11'd0, 1, {ATTR_RESET, 8'd65}, 7'd1, 5'd0);
    add_row(CMD_PUTC, 8'd0, 32'd0, 11'd0, 0, '0, '0, '0);
    add_row(CMD_PUTC, 8'd255, 32'd0, 11'd0, 0, '0, '0, '0);
    add_row(CMD_PUTC, CHAR_NEWLINE, 32'd0, 11'd0, 1, 16'd0, 7'd0, 5'd1);
    add_row(CMD_DEC, 8'd0, 32'd0, 11'd0, 0, '0, '0, '0);
    add_row(CMD_DEC, 8'd0, 32'h7fffffff, 11'd0, 0, '0, '0, '0);
    add_row(CMD_DEC, 8'd0, 32'h80000000, 11'd0, 0, '0, '0, '0);
    add_row(CMD_DEC, 8'd0, 32'hffffffff, 11'd0, 0, '0, '0, '0);
    add_row(CMD_HEX, 8'd0, 32'h80000000, 11'd0, 0, '0, '0, '0);
    add_row(CMD_HEX, 8'd0, 32'h7fffffff, 11'd0, 0, '0, '0, '0);
    add_row(CMD_HEX, 8'd0, 32'hffffffff, 11'd0, 0, '0, '0, '0);
    add_row(CMD_HEX, 8'd0, 32'h00abcdef, 11'd0, 0, '0, '0, '0);
    add_row(CMD_READ, 8'd0, 32'd0, 11'd80, 0, '0, '0, '0);
    add_row(CMD_READ, 8'd0, 32'd0, 11'd95, 0, '0, '0, '0);
    add_row(CMD_SPARE5, 8'd255, 32'hffffffff, 11'd2047, 0, '0, '0, '0);
    add_row(CMD_SPARE6, 8'd0, 32'd0, 11'd0, 0, '0, '0, '0);
    add_row(CMD_CLEAR, 8'd0, 32'd0, 11'd0, 1, 16'd0, 7'd0, 5'd0);
    add_row(CMD_READ, 8'd0, 32'd0, 11'd0, 1, 16'd0, 7'd0, 5'd0);
    add_row(CMD_NO_OP, 8'd0, 32'd0, 11'd0, 1, 16'd0, 7'd0, 5'd0);
    foreach (directed_rows[i]) send_item(directed_rows[i]);
    go_idle_and_drain();

    // Random phases, each at its own attribute; the last runs without idling.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_attribute(8'd0);
        1: set_attribute(8'd255);
        2: set_attribute(8'($urandom_range(1, 254)));
        default: begin
          set_attribute(8'($urandom_range(0, 255)));
          quiet_mode = 1'b1;
        end
      endcase
      if (phase == 0) hold_request = 1'b1;
      for (int n = 0; n < RAND_PER_PHASE; n++) send_item(random_row());
      go_idle_and_drain();
    end

    repeat (50) @(posedge clk_i);
    if (error_count == 0 && pending_reports.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver back-pressure: random bursts, plus one long hold on request.
  initial begin
    int unsigned hold_cycles;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_cycles = 0;
        out_stall <= 1'b1;
        while (hold_cycles < LONG_HOLD) begin
          @(negedge clk_i);
          hold_cycles++;
        end
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end
      else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
        out_stall <= 1'b0;
      end
      else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker: compares every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    cursor_report_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result data=%h col=%0d row=%0d scroll=%b", $time,
                 cell_data, cursor_column, cursor_line, did_scroll);
        error_count++;
      end
      else begin
        want = pending_reports.pop_front();
        if (cell_data !== want.data) begin
          $display("%0t: cell_data expected %h actual %h", $time, want.data, cell_data);
          error_count++;
        end
        if (cursor_column !== want.col) begin
          $display("%0t: cursor_column expected %0d actual %0d", $time, want.col,
                   cursor_column);
          error_count++;
        end
        if (cursor_line !== want.row) begin
          $display("%0t: cursor_line expected %0d actual %0d", $time, want.row, cursor_line);
          error_count++;
        end
        if (did_scroll !== want.scrolled) begin
          $display("%0t: did_scroll expected %b actual %b", $time, want.scrolled,
                   did_scroll);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
